// File: rtl/core/tekd_pkg.sv
// Shared types, constants and key sequence table for the escape key decoder.
`default_nettype none

package tekd_pkg;

  // Sequence geometry.
  localparam int unsigned KeyCount = 16;
  localparam int unsigned SeqMax   = 5;
  localparam int unsigned PendMax  = 4;

  localparam logic [7:0] KeyEsc = 8'h1B;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_PASS    = 2'd0,
    ST_PENDING = 2'd1,
    ST_UNKNOWN = 2'd2,
    ST_KEY     = 2'd3
  } status_e;

  // One decoded result.
  typedef struct packed {
    status_e    status;
    logic [3:0] key_code;
    logic [7:0] byte_out;
  } result_t;

  // Bytes of the sequence in progress and how many of them are valid.
  typedef struct packed {
    logic [PendMax-1:0][7:0] bytes;
    logic [2:0]              count;
  } pend_t;

  // Number of bytes in each key sequence.
  localparam logic [2:0] KEY_LEN [KeyCount] = '{
    3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
    3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd4, 3'd4, 3'd4
  };

  // Key sequences in table order; the first entry that fits decides.
  localparam logic [7:0] KEY_SEQ [KeyCount][SeqMax] = '{
    '{8'h1B, 8'h5B, 8'h41, 8'h00, 8'h00},  // up
    '{8'h1B, 8'h5B, 8'h42, 8'h00, 8'h00},  // down
    '{8'h1B, 8'h5B, 8'h43, 8'h00, 8'h00},  // right
    '{8'h1B, 8'h5B, 8'h44, 8'h00, 8'h00},  // left
    '{8'h1B, 8'h4F, 8'h50, 8'h00, 8'h00},  // F1
    '{8'h1B, 8'h4F, 8'h51, 8'h00, 8'h00},  // F2
    '{8'h1B, 8'h4F, 8'h52, 8'h00, 8'h00},  // F3
    '{8'h1B, 8'h4F, 8'h53, 8'h00, 8'h00},  // F4
    '{8'h1B, 8'h5B, 8'h31, 8'h35, 8'h7E},  // F5
    '{8'h1B, 8'h5B, 8'h31, 8'h37, 8'h7E},  // F6
    '{8'h1B, 8'h5B, 8'h31, 8'h38, 8'h7E},  // F7
    '{8'h1B, 8'h5B, 8'h31, 8'h39, 8'h7E},  // F8
    '{8'h1B, 8'h5B, 8'h32, 8'h30, 8'h7E},  // F9
    '{8'h1B, 8'h5B, 8'h33, 8'h7E, 8'h00},  // delete
    '{8'h1B, 8'h5B, 8'h31, 8'h7E, 8'h00},  // home
    '{8'h1B, 8'h5B, 8'h34, 8'h7E, 8'h00}   // end
  };

endpackage

`default_nettype wire

// File: rtl/core/tekd_match.sv
// Combinational matcher: decodes one byte against the pending sequence.
`default_nettype none

module tekd_match
  import tekd_pkg::*;
(
  input  logic [7:0] byte_i,
  input  pend_t      pend_i,
  output result_t    res_o,
  output pend_t      pend_o
);

  logic [2:0]              cnt;
  logic [2:0]              n;
  logic [SeqMax-1:0][7:0]  cand;
  logic [KeyCount-1:0]     full;
  logic [KeyCount-1:0]     prefix;

  // Candidate sequence: pending bytes followed by the new byte.
  always_comb begin
    cnt = (pend_i.count > 3'(PendMax)) ? 3'(PendMax) : pend_i.count;
    n   = cnt + 3'd1;
    for (int i = 0; i < SeqMax; i++) begin
      if (i < int'(cnt)) begin
        cand[i] = (i < PendMax) ? pend_i.bytes[i[1:0]] : 8'h00;
      end else if (i == int'(cnt)) begin
        cand[i] = byte_i;
      end else begin
        cand[i] = 8'h00;
      end
    end
  end

  // Per entry: complete match, or the candidate is a strict prefix of it.
  always_comb begin
    logic ok_len;
    logic ok_n;
    for (int k = 0; k < KeyCount; k++) begin
      ok_len = 1'b1;
      ok_n   = 1'b1;
      for (int i = 0; i < SeqMax; i++) begin
        if (cand[i] != KEY_SEQ[k][i]) begin
          if (i < int'(KEY_LEN[k])) ok_len = 1'b0;
          if (i < int'(n))          ok_n   = 1'b0;
        end
      end
      full[k]   = (KEY_LEN[k] <= n) && ok_len;
      prefix[k] = (n < KEY_LEN[k]) && ok_n;
    end
  end

  // Escape handling, pass-through, and the first table entry that fits.
  always_comb begin
    res_o  = '{status: ST_UNKNOWN, key_code: 4'd0, byte_out: 8'h00};
    pend_o = '0;
    if (byte_i == KeyEsc) begin
      if (pend_i.count == 3'd1) begin
        // Second escape right after a lone escape passes through.
        res_o.status   = ST_PASS;
        res_o.byte_out = byte_i;
      end else begin
        res_o.status    = ST_PENDING;
        pend_o.bytes[0] = byte_i;
        pend_o.count    = 3'd1;
      end
    end else if (pend_i.count == 3'd0) begin
      res_o.status   = ST_PASS;
      res_o.byte_out = byte_i;
    end else begin
      // Walk from the back so the lowest matching entry wins.
      for (int k = KeyCount - 1; k >= 0; k--) begin
        if (full[k]) begin
          res_o.status   = ST_KEY;
          res_o.key_code = 4'(k);
          pend_o         = '0;
        end else if (prefix[k]) begin
          if (n > 3'(PendMax)) begin
            res_o.status   = ST_UNKNOWN;
            res_o.key_code = 4'd0;
            pend_o         = '0;
          end else begin
            res_o.status   = ST_PENDING;
            res_o.key_code = 4'd0;
            for (int i = 0; i < PendMax; i++) begin
              pend_o.bytes[i] = cand[i];
            end
            pend_o.count = n;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/terminal_escape_key_decoder.sv
// Pipeline: each byte passes the input register, then the result register.
// Throughput: one byte per cycle while the output is not stalled; the key
// match is a single pass between the input register and the result register,
// and the pending buffer updates as each byte moves into the result register.
// Reset: asynchronous, active low; clears both stage valids and empties the
// pending sequence buffer.
`default_nettype none

module terminal_escape_key_decoder
  import tekd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] status_o,
  output logic [3:0] key_code_o,
  output logic [7:0] byte_out_o
);

  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       out_valid_q;
  result_t    res_q;
  result_t    res_d;
  pend_t      pend_q;
  pend_t      pend_d;
  logic       out_ready;
  logic       s1_ready;
  logic       advance;

  // Stage flow control: each stage takes a transfer when it is empty or
  // its content moves on in the same cycle.
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s1_ready   = !s1_valid_q || out_ready;
  assign advance    = s1_valid_q && out_ready;
  assign in_stall_o = !s1_ready;

  tekd_match u_match (
    .byte_i (s1_byte_q),
    .pend_i (pend_q),
    .res_o  (res_d),
    .pend_o (pend_d)
  );

  // Control state and the pending buffer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pend_q      <= '0;
    end else begin
      if (s1_ready) s1_valid_q <= in_valid_i;
      if (out_ready) out_valid_q <= s1_valid_q;
      if (advance) pend_q <= pend_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) s1_byte_q <= rx_byte_i;
    if (advance) res_q <= res_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = res_q.status;
  assign key_code_o  = res_q.key_code;
  assign byte_out_o  = res_q.byte_out;

endmodule

`default_nettype wire
